// ----- rtl/core/ipv4pf_pkg.sv -----
package ipv4pf_pkg;

    localparam int unsigned COUNTER_WIDTH_DEF = 64;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;
    localparam logic [3:0]  MIN_IHL        = 4'd5;
    localparam logic [6:0]  ETH_HDR_LEN    = 7'd14;
    localparam logic [15:0] MIN_FRAME_LEN  = 16'd34;
    localparam logic [6:0]  TCP_HDR_LEN    = 7'd20;
    localparam logic [6:0]  UDP_HDR_LEN    = 7'd8;

    // byte positions inside the frame
    localparam logic [15:0] POS_ETYPE_HI   = 16'd12;
    localparam logic [15:0] POS_ETYPE_LO   = 16'd13;
    localparam logic [15:0] POS_IHL        = 16'd14;
    localparam logic [15:0] POS_PROTO      = 16'd23;
    localparam logic [15:0] POS_L4_FIRST   = 16'd15;
    localparam logic [15:0] OFFSET_MAX     = 16'hFFFF;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MATCH_PORT     = 2'd0,
        REG_MATCH_PROTOCOL = 2'd1,
        REG_DROP_ON_MATCH  = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        OUT_BYPASS    = 2'd0,
        OUT_UNMATCHED = 2'd1,
        OUT_MATCHED   = 2'd2
    } outcome_t;

    // what the parser hands to the counter stage at the end of a frame
    typedef struct packed {
        logic [15:0] len;
        logic        bypass;
        logic [7:0]  proto;
        logic [15:0] dport;
        logic        tcp_udp;
        logic        l4_fit;
    } frame_sum_t;

endpackage

// ----- rtl/core/ipv4_port_filter_with_counters_unit.sv -----
// Channel  Dir  Handshake          Payload
// s_       in   s_tvalid/s_tready  s_tdata: frame_byte; s_tlast: frame_end
// m_       out  m_tvalid/m_tready  m_tdata: verdict, outcome, frame_length, counters
// cfg_     in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// One byte per cycle while s_tready is high. After a frame's last word, the
// parser registers a frame summary, then the counter stage updates the counters
// and loads the output register. Each stage stalls only when the stage after it
// is full and not draining, so bytes keep flowing while a result waits.
// aresetn is synchronous; it clears counters, config and frame state.
module ipv4_port_filter_with_counters_unit #(
    parameter int unsigned COUNTER_WIDTH = ipv4pf_pkg::COUNTER_WIDTH_DEF,
    localparam int unsigned OUT_BITS = 19 + 3 * COUNTER_WIDTH,
    localparam int unsigned OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,

    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,   // [7:0] frame_byte
    input  logic                               s_tlast,   // frame_end

    output logic                               m_tvalid,
    input  logic                               m_tready,
    // from bit 0: verdict(1), outcome(2), frame_length(16), passed_total,
    // dropped_total, matched_bytes_total (COUNTER_WIDTH each), zero fill
    output logic [OUT_W-1:0]                   m_tdata,

    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ipv4pf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ipv4pf_pkg::CFG_DATA_W-1:0]  cfg_data
);

    // config
    logic [15:0] match_port_reg;
    logic [7:0]  match_proto_reg;
    logic        drop_on_match_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_port_reg    <= '0;
            match_proto_reg   <= '0;
            drop_on_match_reg <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                ipv4pf_pkg::REG_MATCH_PORT:     match_port_reg    <= cfg_data;
                ipv4pf_pkg::REG_MATCH_PROTOCOL: match_proto_reg   <= cfg_data[7:0];
                ipv4pf_pkg::REG_DROP_ON_MATCH:  drop_on_match_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // stage handshakes
    logic out_valid_reg;
    logic sum_valid_reg;
    logic out_ready;
    logic sum_ready;
    logic in_fire;
    logic sum_fire;

    assign out_ready = !out_valid_reg || m_tready;
    assign sum_ready = !sum_valid_reg || out_ready;
    assign s_tready  = sum_ready;
    assign in_fire   = s_tvalid && s_tready;
    assign sum_fire  = sum_valid_reg && out_ready;

    // frame parser
    logic [15:0] offset_reg, offset_next;
    logic [15:0] etype_reg, etype_next;
    logic [3:0]  ihl_reg, ihl_next;
    logic [7:0]  proto_reg, proto_next;
    logic [15:0] dport_reg, dport_next;
    logic [6:0]  l4_cur;
    logic [6:0]  l4_end;
    logic [6:0]  need_len;
    logic        tcp_udp_next;
    logic [15:0] len_next;

    ipv4pf_pkg::frame_sum_t sum_reg, sum_next;

    always_comb begin
        etype_next = etype_reg;
        ihl_next   = ihl_reg;
        proto_next = proto_reg;
        dport_next = dport_reg;
        l4_cur     = ipv4pf_pkg::ETH_HDR_LEN + {1'b0, ihl_reg, 2'b00};

        if (offset_reg == ipv4pf_pkg::POS_ETYPE_HI) begin
            etype_next[15:8] = s_tdata;
        end else if (offset_reg == ipv4pf_pkg::POS_ETYPE_LO) begin
            etype_next[7:0] = s_tdata;
        end else if (offset_reg == ipv4pf_pkg::POS_IHL) begin
            ihl_next = s_tdata[3:0];
        end else if (offset_reg == ipv4pf_pkg::POS_PROTO) begin
            proto_next = s_tdata;
        end
        // destination port sits two bytes into the L4 header
        if (offset_reg >= ipv4pf_pkg::POS_L4_FIRST &&
            offset_reg == 16'(l4_cur) + 16'd2) begin
            dport_next[15:8] = s_tdata;
        end else if (offset_reg >= ipv4pf_pkg::POS_L4_FIRST &&
                     offset_reg == 16'(l4_cur) + 16'd3) begin
            dport_next[7:0] = s_tdata;
        end

        len_next = (offset_reg == ipv4pf_pkg::OFFSET_MAX) ? offset_reg
                                                          : offset_reg + 16'd1;
        offset_next = len_next;

        tcp_udp_next = (proto_next == ipv4pf_pkg::PROTO_TCP) ||
                       (proto_next == ipv4pf_pkg::PROTO_UDP);
        l4_end   = ipv4pf_pkg::ETH_HDR_LEN + {1'b0, ihl_next, 2'b00};
        need_len = l4_end + ((proto_next == ipv4pf_pkg::PROTO_TCP) ?
                             ipv4pf_pkg::TCP_HDR_LEN : ipv4pf_pkg::UDP_HDR_LEN);

        sum_next.len     = len_next;
        sum_next.bypass  = !(len_next >= ipv4pf_pkg::MIN_FRAME_LEN &&
                             etype_next == ipv4pf_pkg::ETHERTYPE_IPV4 &&
                             ihl_next >= ipv4pf_pkg::MIN_IHL);
        sum_next.proto   = proto_next;
        sum_next.dport   = dport_next;
        sum_next.tcp_udp = tcp_udp_next;
        sum_next.l4_fit  = 16'(need_len) <= len_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg <= '0;
            etype_reg  <= '0;
            ihl_reg    <= '0;
            proto_reg  <= '0;
            dport_reg  <= '0;
        end else if (in_fire) begin
            if (s_tlast) begin
                offset_reg <= '0;
                etype_reg  <= '0;
                ihl_reg    <= '0;
                proto_reg  <= '0;
                dport_reg  <= '0;
            end else begin
                offset_reg <= offset_next;
                etype_reg  <= etype_next;
                ihl_reg    <= ihl_next;
                proto_reg  <= proto_next;
                dport_reg  <= dport_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_valid_reg <= 1'b0;
        end else if (sum_ready) begin
            sum_valid_reg <= in_fire && s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire && s_tlast) begin
            sum_reg <= sum_next;
        end
    end

    // match and counters
    logic [COUNTER_WIDTH-1:0] pass_cnt_reg, pass_cnt_next;
    logic [COUNTER_WIDTH-1:0] drop_cnt_reg, drop_cnt_next;
    logic [COUNTER_WIDTH-1:0] byte_cnt_reg, byte_cnt_next;
    logic                     matched;
    logic                     proto_ok;
    logic                     port_ok;
    logic                     verdict_next;
    ipv4pf_pkg::outcome_t     outcome_next;

    logic                     verdict_reg;
    ipv4pf_pkg::outcome_t     outcome_reg;
    logic [15:0]              len_reg;

    always_comb begin
        proto_ok = (match_proto_reg == 8'd0) || (match_proto_reg == sum_reg.proto);
        port_ok  = (match_port_reg == 16'd0) ||
                   (sum_reg.l4_fit && sum_reg.dport == match_port_reg);
        matched  = proto_ok && (!sum_reg.tcp_udp || port_ok);

        pass_cnt_next = pass_cnt_reg;
        drop_cnt_next = drop_cnt_reg;
        byte_cnt_next = byte_cnt_reg;
        verdict_next  = 1'b0;
        outcome_next  = ipv4pf_pkg::OUT_BYPASS;

        if (!sum_reg.bypass) begin
            if (!matched) begin
                outcome_next  = ipv4pf_pkg::OUT_UNMATCHED;
                pass_cnt_next = pass_cnt_reg + COUNTER_WIDTH'(1);
            end else begin
                outcome_next  = ipv4pf_pkg::OUT_MATCHED;
                byte_cnt_next = byte_cnt_reg + COUNTER_WIDTH'(sum_reg.len);
                if (drop_on_match_reg) begin
                    verdict_next  = 1'b1;
                    drop_cnt_next = drop_cnt_reg + COUNTER_WIDTH'(1);
                end else begin
                    pass_cnt_next = pass_cnt_reg + COUNTER_WIDTH'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pass_cnt_reg  <= '0;
            drop_cnt_reg  <= '0;
            byte_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (sum_fire) begin
                pass_cnt_reg <= pass_cnt_next;
                drop_cnt_reg <= drop_cnt_next;
                byte_cnt_reg <= byte_cnt_next;
            end
            if (out_ready) begin
                out_valid_reg <= sum_fire;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (sum_fire) begin
            verdict_reg <= verdict_next;
            outcome_reg <= outcome_next;
            len_reg     <= sum_reg.len;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'({byte_cnt_reg, drop_cnt_reg, pass_cnt_reg,
                              len_reg, outcome_reg, verdict_reg});

    // checks
    a_result_from_summary: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(sum_valid_reg))
        else $error("result appeared without a frame summary");

    a_drop_only_on_verdict: assert property (@(posedge aclk) disable iff (!aresetn)
        sum_fire && !verdict_next |=> $stable(drop_cnt_reg))
        else $error("drop counter moved on a passed frame");

    a_verdict_is_matched: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && verdict_reg |-> outcome_reg == ipv4pf_pkg::OUT_MATCHED)
        else $error("drop verdict on a frame that did not match");

    a_bypass_keeps_counters: assert property (@(posedge aclk) disable iff (!aresetn)
        sum_fire && sum_reg.bypass |=>
            $stable(pass_cnt_reg) && $stable(byte_cnt_reg))
        else $error("bypassed frame changed a counter");

    a_frame_state_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && s_tlast |=> offset_reg == 16'd0 && ihl_reg == 4'd0)
        else $error("frame state not cleared after last word");

endmodule

// ----- verif/tb_ipv4_port_filter_with_counters_unit.sv -----
module tb_ipv4_port_filter_with_counters_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CNT_W         = int'(ipv4pf_pkg::COUNTER_WIDTH_DEF);
    localparam int OUT_W         = ((19 + 3 * CNT_W + 7) / 8) * 8;
    localparam int CYCLE_LIMIT   = 100_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 20;
    localparam int HOLD_CYCLES   = 400;
    localparam logic [ipv4pf_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
    localparam logic [15:0] ETHERTYPE_IPV6 = 16'h86DD;

    logic                               aclk      = 1'b0;
    logic                               aresetn   = 1'b0;
    logic                               s_tvalid  = 1'b0;
    logic                               s_tready;
    logic [7:0]                         s_tdata   = '0;   // [7:0] frame_byte
    logic                               s_tlast   = 1'b0; // frame_end
    logic                               m_tvalid;
    logic                               m_tready  = 1'b0;
    // verdict, outcome, frame_length, passed, dropped, matched bytes
    logic [OUT_W-1:0]                   m_tdata;
    logic                               cfg_valid = 1'b0;
    logic                               cfg_ready;
    logic [ipv4pf_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [ipv4pf_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

    typedef struct {
        logic                 verdict;
        ipv4pf_pkg::outcome_t outcome;
        logic [15:0]          length;
        logic [CNT_W-1:0]     passed;
        logic [CNT_W-1:0]     dropped;
        logic [CNT_W-1:0]     mbytes;
    } frame_result_t;

    frame_result_t result_q[$];

    // shadow of the filter registers
    logic [15:0]      cf_port  = '0;
    logic [7:0]       cf_proto = '0;
    logic             cf_drop  = 1'b0;
    // per-frame capture and running totals
    logic [15:0]      pos_cnt   = '0;
    logic [15:0]      etype_cap = '0;
    logic [3:0]       ihl_cap   = '0;
    logic [7:0]       proto_cap = '0;
    logic [15:0]      dport_cap = '0;
    logic [CNT_W-1:0] pass_cnt  = '0;
    logic [CNT_W-1:0] drop_cnt  = '0;
    logic [CNT_W-1:0] mbyte_cnt = '0;

    logic hold_on       = 1'b0;
    int   src_idle_pct  = 0;
    int   snk_stall_pct = 0;
    int   errors        = 0;
    int   cycle_cnt     = 0;
    int   bytes_sent    = 0;
    int   frames_sent   = 0;
    int   results_seen  = 0;
    int   in_stalls     = 0;
    int   n_bypass      = 0;
    int   n_unmatched   = 0;
    int   n_matched     = 0;
    int   n_dropped     = 0;

    ipv4_port_filter_with_counters_unit #(
        .COUNTER_WIDTH(CNT_W)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 aclk = ~aclk;

    // Advance the filter by one accepted word; queue a verdict on the last byte.
    task automatic filter_byte(input logic [7:0] b, input logic last);
        logic [15:0]   pos;
        logic [15:0]   l4;
        int            need;
        bit            hit;
        frame_result_t r;
        pos = pos_cnt;
        l4  = 16'(ipv4pf_pkg::ETH_HDR_LEN) + 16'({ihl_cap, 2'b00});
        if (pos == ipv4pf_pkg::POS_ETYPE_HI) etype_cap[15:8] = b;
        else if (pos == ipv4pf_pkg::POS_ETYPE_LO) etype_cap[7:0] = b;
        else if (pos == ipv4pf_pkg::POS_IHL) ihl_cap = b[3:0];
        else if (pos == ipv4pf_pkg::POS_PROTO) proto_cap = b;
        if (pos >= ipv4pf_pkg::POS_L4_FIRST && pos == l4 + 16'd2) dport_cap[15:8] = b;
        else if (pos >= ipv4pf_pkg::POS_L4_FIRST && pos == l4 + 16'd3) dport_cap[7:0] = b;
        if (pos_cnt != ipv4pf_pkg::OFFSET_MAX) pos_cnt++;
        if (!last) return;

        r.verdict = 1'b0;
        r.outcome = ipv4pf_pkg::OUT_BYPASS;
        r.length  = pos_cnt;
        if (pos_cnt >= ipv4pf_pkg::MIN_FRAME_LEN &&
            etype_cap == ipv4pf_pkg::ETHERTYPE_IPV4 &&
            ihl_cap >= ipv4pf_pkg::MIN_IHL) begin
            hit = (cf_proto == 8'd0) || (cf_proto == proto_cap);
            if (hit && cf_port != 16'd0 &&
                (proto_cap == ipv4pf_pkg::PROTO_TCP || proto_cap == ipv4pf_pkg::PROTO_UDP)) begin
                // header length is final by now
                need = int'(ipv4pf_pkg::ETH_HDR_LEN) + int'(ihl_cap) * 4 +
                       ((proto_cap == ipv4pf_pkg::PROTO_TCP) ? int'(ipv4pf_pkg::TCP_HDR_LEN)
                                                             : int'(ipv4pf_pkg::UDP_HDR_LEN));
                hit = (need <= int'(pos_cnt)) && (dport_cap == cf_port);
            end
            if (!hit) begin
                r.outcome = ipv4pf_pkg::OUT_UNMATCHED;
                pass_cnt++;
                n_unmatched++;
            end else begin
                r.outcome = ipv4pf_pkg::OUT_MATCHED;
                mbyte_cnt = mbyte_cnt + CNT_W'(pos_cnt);
                n_matched++;
                if (cf_drop) begin
                    r.verdict = 1'b1;
                    drop_cnt++;
                    n_dropped++;
                end else begin
                    pass_cnt++;
                end
            end
        end else begin
            n_bypass++;
        end
        r.passed  = pass_cnt;
        r.dropped = drop_cnt;
        r.mbytes  = mbyte_cnt;
        result_q.push_back(r);

        pos_cnt   = '0;
        etype_cap = '0;
        ihl_cap   = '0;
        proto_cap = '0;
        dport_cap = '0;
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        while (int'($urandom_range(99)) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        filter_byte(b, last);
        bytes_sent++;
    endtask

    // Frame of random bytes with the header fields laid in where they fit.
    task automatic send_pkt(input int len, input logic [15:0] etype, input logic [3:0] ihl,
                            input logic [7:0] proto, input logic [15:0] dport);
        logic [7:0] b;
        int         l4;
        l4 = int'(ipv4pf_pkg::ETH_HDR_LEN) + int'(ihl) * 4;
        for (int i = 0; i < len; i++) begin
            b = 8'($urandom_range(255));
            if (i == 12) b = etype[15:8];
            else if (i == 13) b = etype[7:0];
            else if (i == 14) b = {b[7:4], ihl};
            else if (i == 23) b = proto;
            else if (i >= 15 && i == l4 + 2) b = dport[15:8];
            else if (i >= 15 && i == l4 + 3) b = dport[7:0];
            send_byte(b, i == len - 1);
        end
        frames_sent++;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (result_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [ipv4pf_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [15:0] val);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            ipv4pf_pkg::REG_MATCH_PORT:     cf_port  = val;
            ipv4pf_pkg::REG_MATCH_PROTOCOL: cf_proto = val[7:0];
            ipv4pf_pkg::REG_DROP_ON_MATCH:  cf_drop  = val[0];
            default: ;
        endcase
    endtask

    task automatic set_filter(input logic [15:0] port, input logic [7:0] proto,
                              input logic drop);
        logic [15:0] junk;
        junk = 16'($urandom_range(65535));
        // upper data bits of the narrow registers carry noise
        write_reg(ipv4pf_pkg::REG_MATCH_PORT, port);
        write_reg(ipv4pf_pkg::REG_MATCH_PROTOCOL, {junk[15:8], proto});
        write_reg(ipv4pf_pkg::REG_DROP_ON_MATCH, {junk[14:0], drop});
    endtask

    task automatic cmp_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        frame_result_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            if (result_q.size() == 0) begin
                $display("%0t: result word with no frame outstanding: %0h", $time, m_tdata);
                errors++;
            end else begin
                exp_r = result_q.pop_front();
                cmp_field("verdict", 64'(exp_r.verdict), 64'(m_tdata[0]));
                cmp_field("outcome", 64'(exp_r.outcome), 64'(m_tdata[2:1]));
                cmp_field("frame_length", 64'(exp_r.length), 64'(m_tdata[18:3]));
                cmp_field("passed_total", 64'(exp_r.passed), 64'(m_tdata[19 +: CNT_W]));
                cmp_field("dropped_total", 64'(exp_r.dropped),
                          64'(m_tdata[19 + CNT_W +: CNT_W]));
                cmp_field("matched_bytes_total", 64'(exp_r.mbytes),
                          64'(m_tdata[19 + 2 * CNT_W +: CNT_W]));
                results_seen++;
            end
        end
        if (s_tvalid && !s_tready) in_stalls++;
        m_tready <= !hold_on && (int'($urandom_range(99)) >= snk_stall_pct);
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_cnt++;
        end
        $display("%0t: run did not complete within %0d cycles", $time, CYCLE_LIMIT);
        $display("tb_ipv4_port_filter_with_counters_unit failed");
        $finish;
    end

    // Reset config: short, non-IPv4 and bad-IHL frames bypass; anything else matches.
    task automatic test_bypass_cases();
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        send_pkt(1, ipv4pf_pkg::ETHERTYPE_IPV4, ipv4pf_pkg::MIN_IHL,
                 ipv4pf_pkg::PROTO_TCP, 16'd80);
        send_pkt(33, ipv4pf_pkg::ETHERTYPE_IPV4, ipv4pf_pkg::MIN_IHL,
                 ipv4pf_pkg::PROTO_TCP, 16'd80);
        // port zero: no L4 needed
        send_pkt(34, ipv4pf_pkg::ETHERTYPE_IPV4, ipv4pf_pkg::MIN_IHL,
                 ipv4pf_pkg::PROTO_TCP, 16'd80);
        send_pkt(40, ETHERTYPE_IPV6, ipv4pf_pkg::MIN_IHL, ipv4pf_pkg::PROTO_UDP, 16'd53);
        send_pkt(40, ipv4pf_pkg::ETHERTYPE_IPV4, 4'd4, ipv4pf_pkg::PROTO_UDP, 16'd53);
        send_pkt(40, ipv4pf_pkg::ETHERTYPE_IPV4, 4'd0, 8'd1, 16'd0);
        send_pkt(34, ipv4pf_pkg::ETHERTYPE_IPV4, 4'd15, 8'd1, 16'd0);
        send_pkt(40, 16'hFFFF, 4'd15, 8'hFF, 16'hFFFF);
        send_pkt(34, 16'h0000, 4'd0, 8'h00, 16'h0000);
    endtask

    task automatic test_port_match();
        src_idle_pct = 12;
        set_filter(16'd80, ipv4pf_pkg::PROTO_TCP, 1'b1);
        send_pkt(54, ipv4pf_pkg::ETHERTYPE_IPV4, ipv4pf_pkg::MIN_IHL,
                 ipv4pf_pkg::PROTO_TCP, 16'd80);
        // header one byte short
        send_pkt(53, ipv4pf_pkg::ETHERTYPE_IPV4, ipv4pf_pkg::MIN_IHL,
                 ipv4pf_pkg::PROTO_TCP, 16'd80);
        send_pkt(54, ipv4pf_pkg::ETHERTYPE_IPV4, ipv4pf_pkg::MIN_IHL,
                 ipv4pf_pkg::PROTO_TCP, 16'd81);
        send_pkt(42, ipv4pf_pkg::ETHERTYPE_IPV4, ipv4pf_pkg::MIN_IHL,
                 ipv4pf_pkg::PROTO_UDP, 16'd80);
        send_pkt(94, ipv4pf_pkg::ETHERTYPE_IPV4, 4'd15, ipv4pf_pkg::PROTO_TCP, 16'd80);
        send_pkt(93, ipv4pf_pkg::ETHERTYPE_IPV4, 4'd15, ipv4pf_pkg::PROTO_TCP, 16'd80);
        // any protocol, still port-checked for TCP/UDP
        write_reg(ipv4pf_pkg::REG_MATCH_PROTOCOL, 16'd0);
        send_pkt(42, ipv4pf_pkg::ETHERTYPE_IPV4, ipv4pf_pkg::MIN_IHL,
                 ipv4pf_pkg::PROTO_UDP, 16'd80);
        send_pkt(42, ipv4pf_pkg::ETHERTYPE_IPV4, ipv4pf_pkg::MIN_IHL,
                 ipv4pf_pkg::PROTO_UDP, 16'd79);
        send_pkt(40, ipv4pf_pkg::ETHERTYPE_IPV4, ipv4pf_pkg::MIN_IHL, 8'd1, 16'd0);
        set_filter(16'hFFFF, ipv4pf_pkg::PROTO_UDP, 1'b1);
        send_pkt(42, ipv4pf_pkg::ETHERTYPE_IPV4, ipv4pf_pkg::MIN_IHL,
                 ipv4pf_pkg::PROTO_UDP, 16'hFFFF);
        send_pkt(41, ipv4pf_pkg::ETHERTYPE_IPV4, ipv4pf_pkg::MIN_IHL,
                 ipv4pf_pkg::PROTO_UDP, 16'hFFFF);
        send_pkt(42, ipv4pf_pkg::ETHERTYPE_IPV4, ipv4pf_pkg::MIN_IHL,
                 ipv4pf_pkg::PROTO_UDP, 16'hFFFE);
        send_pkt(54, ipv4pf_pkg::ETHERTYPE_IPV4, ipv4pf_pkg::MIN_IHL,
                 ipv4pf_pkg::PROTO_TCP, 16'hFFFF);
    endtask

    task automatic test_protocol_match();
        set_filter(16'd0, 8'hFF, 1'b0);
        send_pkt(34, ipv4pf_pkg::ETHERTYPE_IPV4, ipv4pf_pkg::MIN_IHL, 8'hFF, 16'd0);
        send_pkt(34, ipv4pf_pkg::ETHERTYPE_IPV4, ipv4pf_pkg::MIN_IHL, 8'h00, 16'd0);
        write_reg(ipv4pf_pkg::REG_MATCH_PROTOCOL, 16'(ipv4pf_pkg::PROTO_TCP));
        send_pkt(34, ipv4pf_pkg::ETHERTYPE_IPV4, ipv4pf_pkg::MIN_IHL,
                 ipv4pf_pkg::PROTO_TCP, 16'd0);
        set_filter(16'd0, 8'd0, 1'b1);
        send_pkt(34, ipv4pf_pkg::ETHERTYPE_IPV4, ipv4pf_pkg::MIN_IHL, 8'h00, 16'd0);
    endtask

    // Writes to the spare index and high data bits must not disturb the filter.
    task automatic test_unused_register();
        write_reg(REG_UNUSED, 16'hFFFF);
        send_pkt(36, ipv4pf_pkg::ETHERTYPE_IPV4, ipv4pf_pkg::MIN_IHL, 8'd2, 16'd0);
        write_reg(ipv4pf_pkg::REG_DROP_ON_MATCH, 16'hFFFE);
        send_pkt(36, ipv4pf_pkg::ETHERTYPE_IPV4, ipv4pf_pkg::MIN_IHL, 8'd2, 16'd0);
        write_reg(REG_UNUSED, 16'h0000);
        send_pkt(36, ipv4pf_pkg::ETHERTYPE_IPV4, ipv4pf_pkg::MIN_IHL, 8'd2, 16'd0);
    endtask

    // Receiver blocked while short frames keep coming, so results back up.
    task automatic test_backpressure();
        wait_idle();
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        hold_on <= 1'b1;
        fork
            begin
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_on <= 1'b0;
            end
        join_none
        for (int i = 0; i < 30; i++) begin
            if (i % 10 == 5) begin
                send_pkt(34, ipv4pf_pkg::ETHERTYPE_IPV4, ipv4pf_pkg::MIN_IHL, 8'd1, 16'd0);
            end else begin
                send_pkt(int'($urandom_range(2, 1)), ipv4pf_pkg::ETHERTYPE_IPV4,
                         ipv4pf_pkg::MIN_IHL, 8'd1, 16'd0);
            end
        end
    endtask

    task automatic random_config();
        logic [15:0] port;
        logic [7:0]  proto;
        case ($urandom_range(3))
            0:       port = 16'd0;
            1:       port = 16'hFFFF;
            default: port = 16'($urandom_range(65535));
        endcase
        case ($urandom_range(4))
            0:       proto = 8'd0;
            1:       proto = ipv4pf_pkg::PROTO_TCP;
            2:       proto = ipv4pf_pkg::PROTO_UDP;
            3:       proto = 8'hFF;
            default: proto = 8'($urandom_range(255));
        endcase
        set_filter(port, proto, 1'($urandom_range(1)));
    endtask

    task automatic random_frame();
        int          need;
        int          len;
        logic [3:0]  ihl;
        logic [7:0]  proto;
        logic [15:0] dport;
        if ($urandom_range(99) < 78) begin
            if ($urandom_range(3) == 0) ihl = 4'($urandom_range(15, 5));
            else ihl = ipv4pf_pkg::MIN_IHL;
            case ($urandom_range(5))
                0, 1:    proto = cf_proto;
                2:       proto = ipv4pf_pkg::PROTO_TCP;
                3:       proto = ipv4pf_pkg::PROTO_UDP;
                default: proto = 8'($urandom_range(255));
            endcase
            if ($urandom_range(9) < 7) dport = cf_port;
            else dport = 16'($urandom_range(65535));
            need = int'(ipv4pf_pkg::ETH_HDR_LEN) + int'(ihl) * 4 +
                   ((proto == ipv4pf_pkg::PROTO_TCP) ? int'(ipv4pf_pkg::TCP_HDR_LEN)
                                                     : int'(ipv4pf_pkg::UDP_HDR_LEN));
            case ($urandom_range(4))
                0:       len = need - 1;
                1:       len = need;
                2:       len = int'($urandom_range(need, 34));
                default: len = need + int'($urandom_range(24));
            endcase
            send_pkt(len, ipv4pf_pkg::ETHERTYPE_IPV4, ihl, proto, dport);
        end else begin
            case ($urandom_range(3))
                0: send_pkt(int'($urandom_range(33, 1)), ipv4pf_pkg::ETHERTYPE_IPV4,
                            ipv4pf_pkg::MIN_IHL, 8'($urandom_range(255)),
                            16'($urandom_range(65535)));
                1: send_pkt(int'($urandom_range(80, 34)), 16'($urandom_range(65535)),
                            ipv4pf_pkg::MIN_IHL, 8'($urandom_range(255)),
                            16'($urandom_range(65535)));
                2: send_pkt(int'($urandom_range(80, 34)), ipv4pf_pkg::ETHERTYPE_IPV4,
                            4'($urandom_range(4)), cf_proto, cf_port);
                default: send_pkt(int'($urandom_range(80, 1)), 16'($urandom_range(65535)),
                                  4'($urandom_range(15)), 8'($urandom_range(255)),
                                  16'($urandom_range(65535)));
            endcase
        end
    endtask

    task automatic test_random_traffic();
        int start_bytes;
        for (int ph = 0; ph < 4; ph++) begin
            for (int blk = 0; blk < 2; blk++) begin
                random_config();
                case (ph)
                    0:       begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                    1:       begin src_idle_pct = 59; snk_stall_pct = 0;  end
                    2:       begin src_idle_pct = 0;  snk_stall_pct = 59; end
                    default: begin src_idle_pct = 12; snk_stall_pct = 12; end
                endcase
                start_bytes = bytes_sent;
                while (bytes_sent - start_bytes < 40)
                    random_frame();
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_bypass_cases();
        test_port_match();
        test_protocol_match();
        test_unused_register();
        test_backpressure();
        test_random_traffic();

        s_tvalid <= 1'b0;
        while (result_q.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Covered %0d frames / %0d bytes: %0d bypassed, %0d unmatched,",
                 frames_sent, bytes_sent, n_bypass, n_unmatched);
        $display("%0d matched (%0d dropped); %0d results checked, input held back %0d cycles",
                 n_matched, n_dropped, results_seen, in_stalls);
        if (errors == 0) begin
            $display("tb_ipv4_port_filter_with_counters_unit passed");
        end else begin
            $display("tb_ipv4_port_filter_with_counters_unit failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/ipv4pf_pkg.sv
rtl/core/ipv4_port_filter_with_counters_unit.sv
verif/tb_ipv4_port_filter_with_counters_unit.sv
